### design/swdsq_pkg.sv
// Shared constants and types for the sliding-window squared-deviation block.
package swdsq_pkg;

  localparam int WINDOW_MAX       = 64;
  localparam int ADDR_W           = $clog2(WINDOW_MAX);
  localparam int CNT_W            = $clog2(WINDOW_MAX + 1);
  localparam int LEN_W            = 7;
  localparam int WINDOW_LEN_RESET = 10;
  localparam int WINDOW_LEN_MIN   = 2;
  localparam int SAMPLE_W         = 24;
  localparam int SQ_W             = 2 * SAMPLE_W;
  localparam int SUM_W            = 31;
  localparam int MAG_W            = SUM_W - 1;
  localparam int SUMSQ_W          = 53;
  localparam int DIV_W            = 59;
  localparam int DIV_CNT_W        = $clog2(DIV_W);
  localparam int REM_W            = 6;

  typedef logic [LEN_W-1:0]   len_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [CNT_W-1:0]   cnt_t;

endpackage

### design/swdsq_ram.sv
// Generic single-port-write, registered-read RAM.
module swdsq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/sliding_window_devsq.sv
// Moving sum of squared deviations over a sliding window of samples.
//
// Input channel: in_valid / in_stall with in_sample (signed 24 bit) and
// in_restart. An item is taken when in_valid is high and in_stall low.
// Output channel: out_valid / out_stall with out_devsq_whole,
// out_devsq_remainder and out_valid_res; exactly one result per item.
// The true result is whole + remainder / n, n being window_len held in
// [2, 64]. Until n samples follow a clear, the result is all zero.
// Configuration: cfg_we with cfg_wdata writes window_len and clears the
// window; write only while no item is in flight.
// Timing: one item at a time. A full-window item passes through a ring
// read, two squaring stages and a 59-step restoring divide of sum^2 by n
// before the next item is accepted. Items before the window is full skip
// the divide. The result register sits apart from the sequencer, so a
// stalled result only holds the next item at its final step.
// Reset (synchronous, rst_n low) clears the window, the sums and the output
// valid, and sets window_len to 10. Ring contents are not cleared; an entry
// is only read after it has been written since the last clear.
module sliding_window_devsq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [swdsq_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                          in_restart,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [swdsq_pkg::SUMSQ_W-1:0] out_devsq_whole,
  output logic [swdsq_pkg::REM_W-1:0]   out_devsq_remainder,
  output logic                          out_valid_res,
  input  logic                          cfg_we,
  input  logic [swdsq_pkg::LEN_W-1:0]   cfg_wdata
);

  import swdsq_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_UPD,
    ST_SQ,
    ST_DIV,
    ST_FIN
  } st_t;

  st_t                        state_r;
  len_t                       n_r;
  addr_t                      wp_r;
  cnt_t                       fill_r;
  logic signed [SUM_W-1:0]    sum_r;
  logic [SUMSQ_W-1:0]         sumsq_r;
  logic signed [SAMPLE_W-1:0] x_r;
  logic [SQ_W-1:0]            xsq_r;
  logic [SQ_W-1:0]            osq_r;
  logic                       res_valid_r;
  logic [DIV_W-1:0]           num_r;
  logic [LEN_W-1:0]           rem_r;
  logic [DIV_CNT_W-1:0]       dcnt_r;
  logic                       out_valid_r;
  logic [SUMSQ_W-1:0]         whole_r;
  logic [REM_W-1:0]           frac_r;
  logic                       vres_r;

  logic signed [SAMPLE_W-1:0] rd_data;
  logic                       ram_we;
  logic                       in_acc;
  logic                       full;
  logic signed [SAMPLE_W-1:0] old_s;
  logic [SAMPLE_W-1:0]        xmag;
  logic [SAMPLE_W-1:0]        omag;
  logic [MAG_W-1:0]           smag;
  logic [2*MAG_W-1:0]         ssq;
  logic [LEN_W:0]             trial;
  logic [LEN_W-1:0]           rem_nxt;
  logic [DIV_W-1:0]           num_nxt;
  logic                       qbit;
  logic [ADDR_W:0]            wp_inc;
  len_t                       n_cfg;
  logic                       fin_go;

  swdsq_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WINDOW_MAX)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (x_r),
    .raddr (wp_r),
    .rdata (rd_data)
  );

  assign in_stall = (state_r != ST_IDLE) || cfg_we;
  assign in_acc   = in_valid && !in_stall;
  assign ram_we   = (state_r == ST_UPD);
  assign full     = ({1'b0, fill_r} == {1'b0, n_r});
  assign old_s    = full ? rd_data : '0;

  assign xmag = x_r[SAMPLE_W-1] ? SAMPLE_W'(-x_r) : SAMPLE_W'(x_r);
  assign omag = old_s[SAMPLE_W-1] ? SAMPLE_W'(-old_s) : SAMPLE_W'(old_s);
  assign smag = sum_r[SUM_W-1] ? MAG_W'(-sum_r) : MAG_W'(sum_r);
  assign ssq  = smag * smag;

  assign wp_inc = {1'b0, wp_r} + (ADDR_W+1)'(1);

  // one restoring divide step
  assign trial   = {rem_r, num_r[DIV_W-1]};
  assign qbit    = (trial >= {1'b0, n_r});
  assign rem_nxt = qbit ? LEN_W'(trial - {1'b0, n_r}) : LEN_W'(trial);
  assign num_nxt = {num_r[DIV_W-2:0], qbit};

  assign fin_go = !out_valid_r || !out_stall;

  always_comb begin
    if (cfg_wdata < LEN_W'(WINDOW_LEN_MIN)) begin
      n_cfg = LEN_W'(WINDOW_LEN_MIN);
    end else if (cfg_wdata > LEN_W'(WINDOW_MAX)) begin
      n_cfg = LEN_W'(WINDOW_MAX);
    end else begin
      n_cfg = cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      n_r         <= LEN_W'(WINDOW_LEN_RESET);
      wp_r        <= '0;
      fill_r      <= '0;
      sum_r       <= '0;
      sumsq_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if ((state_r == ST_FIN) && fin_go) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (cfg_we) begin
            n_r     <= n_cfg;
            wp_r    <= '0;
            fill_r  <= '0;
            sum_r   <= '0;
            sumsq_r <= '0;
          end else if (in_acc) begin
            x_r <= in_sample;
            if (in_restart) begin
              wp_r    <= '0;
              fill_r  <= '0;
              sum_r   <= '0;
              sumsq_r <= '0;
            end else begin
              if ({1'b0, wp_r} >= n_r) begin
                wp_r <= '0;
              end
              if ({1'b0, fill_r} > {1'b0, n_r}) begin
                fill_r <= CNT_W'(n_r);
              end
            end
            state_r <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          xsq_r   <= xmag * xmag;
          state_r <= ST_UPD;
        end
        ST_UPD: begin
          osq_r <= omag * omag;
          sum_r <= sum_r - SUM_W'(old_s) + SUM_W'(x_r);
          if (!full) begin
            fill_r <= fill_r + CNT_W'(1);
          end
          res_valid_r <= full || ((fill_r + CNT_W'(1)) == CNT_W'(n_r));
          wp_r    <= (wp_inc == (ADDR_W+1)'(n_r)) ? '0 : wp_inc[ADDR_W-1:0];
          state_r <= ST_SQ;
        end
        ST_SQ: begin
          sumsq_r <= sumsq_r - SUMSQ_W'(osq_r) + SUMSQ_W'(xsq_r);
          num_r   <= ssq[DIV_W-1:0];
          rem_r   <= '0;
          dcnt_r  <= '0;
          state_r <= res_valid_r ? ST_DIV : ST_FIN;
        end
        ST_DIV: begin
          num_r  <= num_nxt;
          rem_r  <= rem_nxt;
          dcnt_r <= dcnt_r + DIV_CNT_W'(1);
          if (dcnt_r == DIV_CNT_W'(DIV_W - 1)) begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (fin_go) begin
            vres_r <= res_valid_r;
            if (!res_valid_r) begin
              whole_r <= '0;
              frac_r  <= '0;
            end else if (rem_r == '0) begin
              whole_r <= sumsq_r - num_r[SUMSQ_W-1:0];
              frac_r  <= '0;
            end else begin
              whole_r <= sumsq_r - num_r[SUMSQ_W-1:0] - SUMSQ_W'(1);
              frac_r  <= REM_W'(n_r - rem_r);
            end
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_devsq_whole     = whole_r;
  assign out_devsq_remainder = frac_r;
  assign out_valid_res       = vres_r;

endmodule

### test/tb_sliding_window_devsq.sv
// Self-checking testbench for the sliding-window sum of squared deviations block.
module tb_sliding_window_devsq;
  timeunit 1ns;
  timeprecision 1ps;

  import swdsq_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int RANDOM_TARGET = 1750;
  localparam int STEADY_ITEMS  = 150;
  localparam int CFG_SETTLE    = 8;
  localparam int TAIL_CYCLES   = 80;

  typedef struct {
    logic [SUMSQ_W-1:0] whole;
    logic [REM_W-1:0]   rem;
    logic               full;
  } devsq_res_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] in_sample = '0;
  logic                       in_restart = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [SUMSQ_W-1:0]         out_devsq_whole;
  logic [REM_W-1:0]           out_devsq_remainder;
  logic                       out_valid_res;
  logic                       cfg_we = 1'b0;
  len_t                       cfg_wdata = '0;

  sliding_window_devsq uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_sample           (in_sample),
    .in_restart          (in_restart),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_devsq_whole     (out_devsq_whole),
    .out_devsq_remainder (out_devsq_remainder),
    .out_valid_res       (out_valid_res),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata)
  );

  always #5 clk = ~clk;

  // window model
  logic signed [SAMPLE_W-1:0] win_ring [WINDOW_MAX];
  int unsigned                wr_ptr;
  int unsigned                fill_cnt;
  longint signed              win_sum;
  longint unsigned            win_sumsq;
  len_t                       win_len_reg;

  devsq_res_t devsq_expected [$];
  bit         idle_en = 1'b1;
  int         failures = 0;
  int         results_checked = 0;
  int         items_sent = 0;
  int         restarts = 0;
  int         cfg_writes = 0;
  int         cycles = 0;
  int         stall_left = 0;
  int         calm_left = 0;

  function automatic int unsigned eff_window();
    int unsigned n;
    n = win_len_reg;
    if (n < WINDOW_LEN_MIN) n = WINDOW_LEN_MIN;
    if (n > WINDOW_MAX) n = WINDOW_MAX;
    return n;
  endfunction

  function automatic void clear_window_model();
    wr_ptr = 0;
    fill_cnt = 0;
    win_sum = 0;
    win_sumsq = 0;
  endfunction

  function automatic devsq_res_t predict_devsq(logic signed [SAMPLE_W-1:0] x, logic restart);
    int unsigned     n;
    longint signed   xs;
    longint signed   old_s;
    longint unsigned sq;
    longint unsigned s;
    longint unsigned a;
    longint unsigned b;
    longint unsigned q;
    longint unsigned r;
    longint unsigned whole;
    devsq_res_t      res;
    n = eff_window();
    xs = x;
    if (restart) clear_window_model();
    if (wr_ptr >= n) wr_ptr = 0;
    if (fill_cnt > n) fill_cnt = n;
    if (fill_cnt == n) begin
      old_s = win_ring[wr_ptr];
      sq = old_s * old_s;
      win_sum -= old_s;
      win_sumsq -= sq;
    end else begin
      fill_cnt++;
    end
    win_ring[wr_ptr] = x;
    sq = xs * xs;
    win_sum += xs;
    win_sumsq += sq;
    wr_ptr = (wr_ptr + 1 == n) ? 0 : wr_ptr + 1;
    res.whole = '0;
    res.rem = '0;
    res.full = 1'b0;
    if (fill_cnt == n) begin
      // |sum| = a*n + b keeps sum^2 / n within 64 bits
      s = (win_sum < 0) ? -win_sum : win_sum;
      a = s / n;
      b = s % n;
      q = a * a * n + 2 * a * b + (b * b) / n;
      r = (b * b) % n;
      if (r == 0) begin
        whole = win_sumsq - q;
        res.rem = '0;
      end else begin
        whole = win_sumsq - q - 1;
        res.rem = REM_W'(n - r);
      end
      res.whole = whole[SUMSQ_W-1:0];
      res.full = 1'b1;
    end
    return res;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return {1'b0, {(SAMPLE_W-1){1'b1}}};
      1: return {1'b1, {(SAMPLE_W-1){1'b0}}};
      2: return SAMPLE_W'($urandom_range(0, 32) - 16);
      default: return SAMPLE_W'($urandom());
    endcase
  endfunction

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] x, input logic restart);
    int gap;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_sample <= x;
    in_restart <= restart;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    devsq_expected.push_back(predict_devsq(x, restart));
    items_sent++;
    if (restart) restarts++;
  endtask

  task automatic wait_results_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (devsq_expected.size() != 0) @(posedge clk);
  endtask

  task automatic write_window_len(input len_t value);
    wait_results_drained();
    repeat (CFG_SETTLE) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    win_len_reg = value;
    clear_window_model();
    cfg_writes++;
  endtask

  // default window of 10, field extremes, restarts, short and undersized windows
  task automatic test_directed();
    send_sample({1'b0, {(SAMPLE_W-1){1'b1}}}, 1'b1);
    send_sample({1'b1, {(SAMPLE_W-1){1'b0}}}, 1'b0);
    send_sample('0, 1'b0);
    send_sample('1, 1'b0);
    send_sample(SAMPLE_W'(1), 1'b0);
    send_sample({1'b0, {(SAMPLE_W-1){1'b1}}}, 1'b0);
    send_sample({1'b1, {(SAMPLE_W-1){1'b0}}}, 1'b0);
    send_sample(SAMPLE_W'(24'h400000), 1'b0);
    send_sample(SAMPLE_W'(24'hC00000), 1'b0);
    send_sample(SAMPLE_W'(12345), 1'b0);
    send_sample(SAMPLE_W'(24'h555555), 1'b0);
    send_sample(SAMPLE_W'(24'hAAAAAA), 1'b0);
    send_sample({1'b0, {(SAMPLE_W-1){1'b1}}}, 1'b1);
    send_sample(SAMPLE_W'(3), 1'b0);
    send_sample(SAMPLE_W'(-7), 1'b0);
    write_window_len(len_t'(2));
    send_sample({1'b1, {(SAMPLE_W-1){1'b0}}}, 1'b0);
    send_sample({1'b1, {(SAMPLE_W-1){1'b0}}}, 1'b0);
    send_sample({1'b0, {(SAMPLE_W-1){1'b1}}}, 1'b0);
    write_window_len(len_t'(0));
    send_sample({1'b0, {(SAMPLE_W-1){1'b1}}}, 1'b0);
    send_sample({1'b1, {(SAMPLE_W-1){1'b0}}}, 1'b0);
    send_sample(SAMPLE_W'(1), 1'b0);
  endtask

  // largest windows, register values beyond both ends of the range
  task automatic test_window_extremes();
    int k;
    write_window_len(len_t'(WINDOW_MAX));
    for (k = 0; k < WINDOW_MAX; k++) send_sample({1'b1, {(SAMPLE_W-1){1'b0}}}, 1'b0);
    for (k = 0; k < 8; k++)
      send_sample(k[0] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}}, 1'b0);
    write_window_len(len_t'(127));
    for (k = 0; k < 70; k++) send_sample(pick_sample(), 1'b0);
    write_window_len(len_t'(1));
    for (k = 0; k < 6; k++) send_sample(pick_sample(), k == 3);
    write_window_len(len_t'(65));
    for (k = 0; k < 66; k++) send_sample(pick_sample(), 1'b0);
  endtask

  task automatic test_random_windows();
    len_t len;
    int   n;
    int   seg;
    int   k;
    while (items_sent < RANDOM_TARGET) begin
      case ($urandom_range(0, 9))
        0: len = len_t'(WINDOW_MAX);
        1: len = len_t'($urandom_range(WINDOW_MAX + 1, 127));
        2: len = len_t'($urandom_range(0, 1));
        default: len = len_t'($urandom_range(2, 16));
      endcase
      write_window_len(len);
      n = eff_window();
      seg = n + $urandom_range(1, 2 * n + 8);
      for (k = 0; k < seg; k++) begin
        if (k == seg / 2 && $urandom_range(0, 3) == 0) wait_results_drained();
        send_sample(pick_sample(), $urandom_range(0, 39) == 0);
      end
    end
  endtask

  task automatic test_steady_stream();
    int k;
    idle_en = 1'b0;
    write_window_len(len_t'(5));
    for (k = 0; k < STEADY_ITEMS; k++) send_sample(pick_sample(), $urandom_range(0, 49) == 0);
  endtask

  always @(negedge clk) begin
    if (!idle_en) begin
      out_stall <= 1'b0;
      stall_left = 0;
      calm_left = 0;
    end else if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (calm_left != 0) begin
      out_stall <= 1'b0;
      calm_left--;
    end else if ($urandom_range(0, 2) == 0) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(0, 3);
    end else begin
      out_stall <= 1'b0;
      calm_left = $urandom_range(0, 30);
    end
  end

  always @(posedge clk) begin
    devsq_res_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      if (devsq_expected.size() == 0) begin
        $error("unexpected item: devsq_whole %0d", out_devsq_whole);
        failures++;
      end else begin
        exp_res = devsq_expected.pop_front();
        results_checked++;
        if (out_devsq_whole !== exp_res.whole) begin
          $error("devsq_whole: expected %0d, got %0d", exp_res.whole, out_devsq_whole);
          failures++;
        end
        if (out_devsq_remainder !== exp_res.rem) begin
          $error("devsq_remainder: expected %0d, got %0d", exp_res.rem, out_devsq_remainder);
          failures++;
        end
        if (out_valid_res !== exp_res.full) begin
          $error("valid_res: expected %0d, got %0d", exp_res.full, out_valid_res);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL sliding_window_devsq");
      $finish;
    end
  end

  initial begin
    win_len_reg = len_t'(WINDOW_LEN_RESET);
    clear_window_model();
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_window_extremes();
    test_random_windows();
    test_steady_stream();
    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d items (%0d with restart) across %0d window settings; %0d results checked.",
             items_sent, restarts, cfg_writes, results_checked);
    if (failures == 0 && devsq_expected.size() == 0) begin
      $display("PASS sliding_window_devsq");
    end else begin
      $display("FAIL sliding_window_devsq");
    end
    $finish;
  end

endmodule
